[design/utfmg_pkg.sv]
package utfmg_pkg;

  // byte, result count and phase widths
  localparam int DATA_W      = 8;
  localparam int OUT_COUNT_W = 6;
  localparam int PHASE_W     = 4;

  // default queue depth
  localparam int FIFO_DEPTH_DEF = 32;

  // register reset values
  localparam logic [DATA_W-1:0] DELIM_RST     = 8'd64;
  localparam logic [DATA_W-1:0] PAUSE_RST     = 8'd20;
  localparam logic [DATA_W-1:0] UNIT_LIM_RST  = 8'd192;

  // register map, index is paddr[3:2]
  typedef enum logic [1:0] {
    REG_DELIM    = 2'd0,
    REG_PAUSE    = 2'd1,
    REG_UNIT_LIM = 2'd2
  } cfg_reg_t;

  // input operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  // frame phases
  localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
  localparam logic [PHASE_W-1:0] PH_START      = 4'd1;
  localparam logic [PHASE_W-1:0] PH_DATA_FIRST = 4'd2;
  localparam logic [PHASE_W-1:0] PH_STOP_FIRST = 4'd10;
  localparam logic [PHASE_W-1:0] PH_HOLD       = 4'd12;

  // queue status seen by the serializer
  typedef struct packed {
    logic              nonempty;
    logic [DATA_W-1:0] head;
  } fifo_stat_t;

endpackage

[design/uart_tx_fifo_with_message_gap.sv]
// UART transmitter, 8 data bits LSB first, two stop bits, fed by a byte FIFO.
// Input channel (in_valid/in_ready): each beat is a tick (in_op 0, one bit
// time) or a push of in_data_byte (in_op 1). A push to a full FIFO is dropped
// and flagged in out_dropped. A popped byte equal to the delimiter register
// is not sent; it starts a pause of pause_units units, each unit_tick_limit+1
// ticks long.
// Output channel (out_valid/out_ready): one result beat per input beat, with
// the line level held before that beat, the FIFO count and busy flag after
// it, and the drop flag.
// The result is valid in the cycle after input accept, from the single output
// register stage; one beat per cycle is accepted while results are taken. A
// new beat is taken while the result waits only if out_ready is high in that
// cycle, so a stalled receiver stalls the input after one beat.
// Registers on the APB port: 0x0 delimiter, 0x4 pause units, 0x8 unit tick
// limit. Reset (rst_n low, synchronous) empties the FIFO, idles the line high
// and loads register defaults 64, 20 and 192; no clearing pass is needed.
module uart_tx_fifo_with_message_gap #(
  parameter int FIFO_DEPTH = utfmg_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [utfmg_pkg::DATA_W-1:0]      in_data_byte,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_line_level,
  output logic [utfmg_pkg::OUT_COUNT_W-1:0] out_fifo_count,
  output logic                              out_busy_res,
  output logic                              out_dropped,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  import utfmg_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH+1);

  logic [DATA_W-1:0]      delim_r, pause_units_r, unit_lim_r;
  logic                   accept, push, tick, pop, full, level, ser_busy;
  logic [CW-1:0]          cnt_nxt;
  logic [CW+OUT_COUNT_W-1:0] cnt_ext;
  fifo_stat_t             stat;
  cfg_reg_t               reg_sel;

  logic                   out_valid_r, line_level_r, busy_r, dropped_r;
  logic [OUT_COUNT_W-1:0] fifo_count_r;

  // handshake
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (in_op == OP_PUSH);
  assign tick     = accept && (in_op == OP_TICK);

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r       <= DELIM_RST;
      pause_units_r <= PAUSE_RST;
      unit_lim_r    <= UNIT_LIM_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_DELIM:    delim_r       <= pwdata[DATA_W-1:0];
        REG_PAUSE:    pause_units_r <= pwdata[DATA_W-1:0];
        REG_UNIT_LIM: unit_lim_r    <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DELIM:    prdata = {24'd0, delim_r};
      REG_PAUSE:    prdata = {24'd0, pause_units_r};
      REG_UNIT_LIM: prdata = {24'd0, unit_lim_r};
      default:      prdata = '0;
    endcase
  end

  // byte queue
  utfmg_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_data_byte),
    .pop       (pop),
    .stat      (stat),
    .full      (full),
    .count_nxt (cnt_nxt)
  );

  // frame and pause sequencer
  utfmg_serializer u_ser (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .stat        (stat),
    .delim       (delim_r),
    .pause_units (pause_units_r),
    .unit_lim    (unit_lim_r),
    .pop         (pop),
    .level       (level),
    .busy_nxt    (ser_busy)
  );

  assign cnt_ext = {{OUT_COUNT_W{1'b0}}, cnt_nxt};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_level_r <= level;
      fifo_count_r <= cnt_ext[OUT_COUNT_W-1:0];
      busy_r       <= ser_busy || (cnt_nxt != '0);
      dropped_r    <= push && full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = line_level_r;
  assign out_fifo_count = fifo_count_r;
  assign out_busy_res   = busy_r;
  assign out_dropped    = dropped_r;

  // checks
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dropped_r |-> busy_r) else $error("drop reported while idle");

endmodule

[design/utfmg_ram.sv]
module utfmg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/utfmg_fifo.sv]
module utfmg_fifo #(
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [utfmg_pkg::DATA_W-1:0]     push_data,
  input  logic                             pop,
  output utfmg_pkg::fifo_stat_t            stat,
  output logic                             full,
  output logic [$clog2(DEPTH+1)-1:0]       count_nxt
);

  import utfmg_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [AW-1:0]     rp_r, rp_nxt, wp_r, wp_nxt, rp_inc, wp_inc;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DATA_W-1:0] head_r, head_nxt, head_eff, ram_q;
  logic              use_q_r, use_q_nxt;
  logic              wr_en;

  // storage
  utfmg_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wp_r),
    .wdata (push_data),
    .re    (pop),
    .raddr (rp_inc),
    .rdata (ram_q)
  );

  // pointer wrap at depth
  assign rp_inc = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
  assign wp_inc = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;

  assign full     = (cnt_r == CW'(DEPTH));
  assign wr_en    = push && !full;
  // head comes from ram the cycle after a pop that left entries behind
  assign head_eff = use_q_r ? ram_q : head_r;

  // pointer, count and head update
  always_comb begin
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_eff;
    use_q_nxt = 1'b0;
    if (wr_en) begin
      wp_nxt  = wp_inc;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '0) begin
        head_nxt = push_data;
      end
    end else if (pop) begin
      rp_nxt    = rp_inc;
      cnt_nxt   = cnt_r - 1'b1;
      use_q_nxt = (cnt_r > CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r    <= '0;
      wp_r    <= '0;
      cnt_r   <= '0;
      use_q_r <= 1'b0;
    end else begin
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      cnt_r   <= cnt_nxt;
      use_q_r <= use_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
  end

  assign stat.nonempty = (cnt_r != '0);
  assign stat.head     = head_eff;
  assign count_nxt     = cnt_nxt;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("fifo count above depth");
  a_use_q_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    use_q_r |-> cnt_r != '0) else $error("ram head used with empty fifo");

endmodule

[design/utfmg_serializer.sv]
module utfmg_serializer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick,
  input  utfmg_pkg::fifo_stat_t        stat,
  input  logic [utfmg_pkg::DATA_W-1:0] delim,
  input  logic [utfmg_pkg::DATA_W-1:0] pause_units,
  input  logic [utfmg_pkg::DATA_W-1:0] unit_lim,
  output logic                         pop,
  output logic                         level,
  output logic                         busy_nxt
);

  import utfmg_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [DATA_W-1:0]  shift_r, shift_nxt;
  logic [DATA_W-1:0]  pause_r, pause_nxt;
  logic [DATA_W-1:0]  unit_r, unit_nxt;
  logic               level_r, level_nxt;

  // one bit time of frame or pause per tick
  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    pause_nxt = pause_r;
    unit_nxt  = unit_r;
    level_nxt = level_r;
    pop       = 1'b0;
    if (tick) begin
      if (pause_r != '0) begin
        if (unit_r < unit_lim) begin
          unit_nxt = unit_r + 1'b1;
        end else begin
          unit_nxt  = '0;
          pause_nxt = pause_r - 1'b1;
        end
      end else if (phase_r == PH_IDLE) begin
        if (stat.nonempty) begin
          pop       = 1'b1;
          shift_nxt = stat.head;
          if (stat.head != delim) begin
            phase_nxt = PH_START;
          end else begin
            pause_nxt = pause_units;
          end
        end
      end else if (phase_r == PH_START) begin
        level_nxt = 1'b0;
        phase_nxt = PH_DATA_FIRST;
      end else if (phase_r < PH_STOP_FIRST) begin
        level_nxt = shift_r[0];
        shift_nxt = {1'b0, shift_r[DATA_W-1:1]};
        phase_nxt = phase_r + 1'b1;
      end else if (phase_r < PH_HOLD) begin
        level_nxt = 1'b1;
        phase_nxt = phase_r + 1'b1;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= '0;
      pause_r <= '0;
      unit_r  <= '0;
      level_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      pause_r <= pause_nxt;
      unit_r  <= unit_nxt;
      level_r <= level_nxt;
    end
  end

  assign level    = level_r;
  assign busy_nxt = (phase_nxt != PH_IDLE) || (pause_nxt != '0);

  // checks
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_HOLD) else $error("frame phase out of range");
  a_pause_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pause_r != '0 |-> phase_r == PH_IDLE) else $error("pause during a frame");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.nonempty) else $error("pop from empty fifo");

endmodule
